@@ hw/rtl/mbsp_pkg.sv @@
// Shared types, constants and helpers of the MIDI byte stream parser.
`timescale 1ns / 1ps
`default_nettype none

package mbsp_pkg;

    localparam int BUFFER_DEPTH = 32;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int LEN_W        = $clog2(BUFFER_DEPTH + 1);
    localparam int CMD_DEPTH    = 4;
    localparam int CMD_PTR_W    = $clog2(CMD_DEPTH);

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam logic [7:0] STATUS_SYSEX     = 8'hF0;
    localparam logic [7:0] STATUS_MTC       = 8'hF1;
    localparam logic [7:0] STATUS_SONG_POS  = 8'hF2;
    localparam logic [7:0] STATUS_SONG_SEL  = 8'hF3;
    localparam logic [7:0] STATUS_UNDEF_F4  = 8'hF4;
    localparam logic [7:0] STATUS_UNDEF_F5  = 8'hF5;
    localparam logic [7:0] STATUS_TUNE_REQ  = 8'hF6;
    localparam logic [7:0] STATUS_SYSEX_END = 8'hF7;
    localparam logic [7:0] REALTIME_MIN     = 8'hF8;
    localparam logic [7:0] REALTIME_UNDEF   = 8'hFD;

    localparam logic [3:0] NIB_PROG_CHANGE  = 4'hC;
    localparam logic [3:0] NIB_CHAN_PRESS   = 4'hD;
    localparam logic [3:0] NIB_SYSTEM       = 4'hF;

    typedef enum logic [2:0] {
        KIND_MSG        = 3'd0,
        KIND_OVERFLOW   = 3'd1,
        KIND_INCOMPLETE = 3'd2,
        KIND_INVALID    = 3'd3,
        KIND_STRAY_END  = 3'd4
    } kind_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [31:0] frame_time;
    } in_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  out_byte;
        logic [31:0] out_time;
        logic        last;
        logic [15:0] byte_count;
        logic [15:0] lost_count;
    } out_item_t;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       out_byte;
        logic [31:0]      out_time;
        logic             last;
        logic [15:0]      byte_count;
        logic [15:0]      lost_count;
        logic             from_store;
        logic [LEN_W-1:0] len;
    } cmd_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } store_wr_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    typedef enum logic [1:0] {
        FR_ACCEPT,
        FR_PUSH_A,
        FR_PUSH_B,
        FR_WAIT
    } front_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_SEND
    } back_state_t;

    function automatic logic [15:0] sat_inc(input logic [15:0] c);
        return (c == COUNT_MAX) ? c : c + 16'd1;
    endfunction

    function automatic cmd_t make_cmd(input kind_t k, input logic [7:0] by,
                                      input logic [31:0] tm, input logic [15:0] bc,
                                      input logic [15:0] lc);
        cmd_t c;
        c            = '0;
        c.kind       = k;
        c.out_byte   = by;
        c.out_time   = tm;
        c.byte_count = bc;
        c.lost_count = lc;
        return c;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/midi_byte_stream_parser_top.sv @@
// Top level of the MIDI byte stream parser.
//
//  channel | ports                      | payload
//  --------+----------------------------+---------------------------------------------
//  input   | s_valid, s_ready, s_item   | data_byte, frame_time
//  result  | m_valid, m_ready, m_item   | kind, out_byte, out_time, last, byte_count,
//          |                            | lost_count
//
// A byte with no result stays in FR_ACCEPT; one with results adds one queue push
// per result (FR_PUSH_A, then FR_PUSH_B), and waits while the queue is full.
// A completed buffered message drains byte by byte through the registered
// read port of the message store; input is held until the last byte has been read.
// Reset clears counters, status and queues; the store is not cleared.
// A 4-entry command queue and the output register let each side stall on its own.
`timescale 1ns / 1ps
`default_nettype none

module midi_byte_stream_parser_top (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire mbsp_pkg::in_item_t  s_item,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output mbsp_pkg::out_item_t      m_item
);
    import mbsp_pkg::*;

    store_wr_t    store_wr;
    logic         push, pop, store_done;
    cmd_t         push_data, pop_data;
    fifo_status_t fifo_status;

    mbsp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_item      (s_item),
        .store_wr    (store_wr),
        .push        (push),
        .push_data   (push_data),
        .fifo_status (fifo_status),
        .store_done  (store_done)
    );

    mbsp_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (fifo_status)
    );

    mbsp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .store_wr    (store_wr),
        .pop         (pop),
        .pop_data    (pop_data),
        .fifo_status (fifo_status),
        .store_done  (store_done),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

`ifndef NO_ASSERTIONS
    a_store_write_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        store_wr.en |-> (s_valid && s_ready))
        else $error("store written without an accepted item");

    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !fifo_status.full)
        else $error("command pushed into a full queue");

    a_front_held_during_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        store_done |-> !s_ready)
        else $error("front end accepting while the store drains");

    a_drain_byte_is_message: assert property (@(posedge aclk) disable iff (!aresetn)
        store_done |=> (m_valid && m_item.kind == KIND_MSG))
        else $error("store drain did not deliver a message byte");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/mbsp_front.sv @@
// Front end: accepts bytes, tracks running status and counts, issues result commands.
`timescale 1ns / 1ps
`default_nettype none

module mbsp_front (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire mbsp_pkg::in_item_t      s_item,
    output mbsp_pkg::store_wr_t          store_wr,
    output logic                         push,
    output mbsp_pkg::cmd_t               push_data,
    input  wire mbsp_pkg::fifo_status_t  fifo_status,
    input  wire logic                    store_done
);
    import mbsp_pkg::*;

    front_state_t state_reg, state_next;

    logic [15:0] bt_reg, bt_next;
    logic [15:0] ut_reg, ut_next;
    logic [1:0]  el_reg, el_next;
    logic [7:0]  rs_reg, rs_next;

    cmd_t cmd_a_reg, cmd_b_reg;
    logic has_b_reg;

    cmd_t cmd_a, cmd_b, cmd_x;
    logic a_v, b_v, x_v;
    logic accept;

    logic        do_rec, do_finish;
    logic [15:0] bt_base, ut_base, bt_rec, ut_rec;

    logic [7:0]  b;
    logic [31:0] t;

    assign b      = s_item.data_byte;
    assign t      = s_item.frame_time;
    assign accept = s_valid && s_ready;

    always_comb begin
        bt_next  = bt_reg;
        ut_next  = ut_reg;
        el_next  = el_reg;
        rs_next  = rs_reg;
        cmd_a    = '0;
        cmd_b    = '0;
        cmd_x    = '0;
        a_v      = 1'b0;
        b_v      = 1'b0;
        x_v      = 1'b0;
        store_wr = '0;
        do_rec   = 1'b0;
        do_finish = 1'b0;
        bt_base  = bt_reg;
        ut_base  = ut_reg;
        bt_rec   = bt_reg;
        ut_rec   = ut_reg;
        if (accept) begin
            if (b >= REALTIME_MIN) begin
                a_v   = 1'b1;
                cmd_a = make_cmd((b == REALTIME_UNDEF) ? KIND_INVALID : KIND_MSG,
                                 b, t, 16'd0, 16'd0);
            end else if (b == STATUS_SYSEX_END) begin
                if (rs_reg == STATUS_SYSEX) begin
                    do_rec    = 1'b1;
                    do_finish = 1'b1;
                end else begin
                    a_v     = 1'b1;
                    cmd_a   = make_cmd(KIND_STRAY_END, STATUS_SYSEX_END, t, bt_reg, 16'd0);
                    bt_next = '0;
                    ut_next = '0;
                    el_next = '0;
                    rs_next = '0;
                end
            end else if (b[7]) begin
                if (bt_reg != 16'd0) begin
                    a_v   = 1'b1;
                    cmd_a = make_cmd(KIND_INCOMPLETE, 8'd0, t, bt_reg, 16'd0);
                end
                bt_base = '0;
                ut_base = '0;
                bt_next = '0;
                ut_next = '0;
                rs_next = b;
                do_rec  = 1'b1;
                unique case (b[7:4])
                    NIB_PROG_CHANGE, NIB_CHAN_PRESS: el_next = 2'd2;
                    NIB_SYSTEM: begin
                        unique case (b) inside
                            STATUS_MTC, STATUS_SONG_SEL: el_next = 2'd2;
                            STATUS_SONG_POS:             el_next = 2'd3;
                            STATUS_UNDEF_F4, STATUS_UNDEF_F5: begin
                                x_v     = 1'b1;
                                cmd_x   = make_cmd(KIND_INVALID, b, t, 16'd0, 16'd0);
                                el_next = '0;
                                rs_next = '0;
                                do_rec  = 1'b0;
                            end
                            STATUS_TUNE_REQ: begin
                                x_v     = 1'b1;
                                cmd_x   = make_cmd(KIND_MSG, b, t, 16'd0, 16'd0);
                                el_next = '0;
                                rs_next = '0;
                                do_rec  = 1'b0;
                            end
                            default: el_next = 2'd0;
                        endcase
                    end
                    default: el_next = 2'd3;
                endcase
            end else begin
                if (rs_reg == 8'd0) begin
                    bt_next = sat_inc(bt_reg);
                    ut_next = sat_inc(ut_reg);
                end else begin
                    // store entry 0 already holds the running status
                    bt_base = (bt_reg == 16'd0) ? 16'd1 : bt_reg;
                    do_rec  = 1'b1;
                end
            end

            if (do_rec) begin
                if (bt_base < 16'(BUFFER_DEPTH)) begin
                    store_wr.en   = 1'b1;
                    store_wr.addr = bt_base[ADDR_W-1:0];
                    store_wr.data = b;
                    ut_rec        = ut_base;
                end else begin
                    ut_rec = sat_inc(ut_base);
                end
                bt_rec  = sat_inc(bt_base);
                bt_next = bt_rec;
                ut_next = ut_rec;
                if (!b[7] && bt_rec == {14'd0, el_reg}) begin
                    do_finish = 1'b1;
                end
            end

            if (do_finish) begin
                a_v = 1'b1;
                if (ut_rec != 16'd0) begin
                    cmd_a = make_cmd(KIND_OVERFLOW, 8'd0, t, bt_rec, ut_rec);
                end else begin
                    cmd_a            = make_cmd(KIND_MSG, 8'd0, t, 16'd0, 16'd0);
                    cmd_a.from_store = 1'b1;
                    cmd_a.len        = bt_rec[LEN_W-1:0];
                end
                bt_next = '0;
                ut_next = '0;
                if (rs_reg >= STATUS_SYSEX) begin
                    el_next = '0;
                    rs_next = '0;
                end
            end

            if (x_v) begin
                if (a_v) begin
                    b_v   = 1'b1;
                    cmd_b = cmd_x;
                end else begin
                    a_v   = 1'b1;
                    cmd_a = cmd_x;
                end
            end

            if (b_v) begin
                cmd_b.last = 1'b1;
            end else if (a_v) begin
                cmd_a.last = 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FR_ACCEPT: if (accept && a_v) state_next = FR_PUSH_A;
            FR_PUSH_A: begin
                if (!fifo_status.full) begin
                    if (has_b_reg) begin
                        state_next = FR_PUSH_B;
                    end else if (cmd_a_reg.from_store) begin
                        state_next = FR_WAIT;
                    end else begin
                        state_next = FR_ACCEPT;
                    end
                end
            end
            FR_PUSH_B: if (!fifo_status.full) state_next = FR_ACCEPT;
            FR_WAIT:   if (store_done) state_next = FR_ACCEPT;
            default:   state_next = FR_ACCEPT;
        endcase
    end

    always_comb begin
        s_ready   = 1'b0;
        push      = 1'b0;
        push_data = cmd_a_reg;
        unique case (state_reg)
            FR_ACCEPT: s_ready = 1'b1;
            FR_PUSH_A: push = !fifo_status.full;
            FR_PUSH_B: begin
                push      = !fifo_status.full;
                push_data = cmd_b_reg;
            end
            FR_WAIT:   s_ready = 1'b0;
            default:   s_ready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FR_ACCEPT;
            bt_reg    <= '0;
            ut_reg    <= '0;
            el_reg    <= '0;
            rs_reg    <= '0;
            has_b_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                bt_reg    <= bt_next;
                ut_reg    <= ut_next;
                el_reg    <= el_next;
                rs_reg    <= rs_next;
                has_b_reg <= b_v;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_a_reg <= cmd_a;
            cmd_b_reg <= cmd_b;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/mbsp_cmd_fifo.sv @@
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module mbsp_cmd_fifo (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire mbsp_pkg::cmd_t  push_data,
    input  wire logic            pop,
    output mbsp_pkg::cmd_t       pop_data,
    output mbsp_pkg::fifo_status_t status
);
    import mbsp_pkg::*;

    cmd_t                 entry_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CMD_PTR_W:0]   count_reg, count_next;

    logic do_push, do_pop;

    assign status.full  = (count_reg == (CMD_PTR_W + 1)'(CMD_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

@@ hw/rtl/mbsp_back.sv @@
// Back end: message store, command execution and the output register.
`timescale 1ns / 1ps
`default_nettype none

module mbsp_back (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire mbsp_pkg::store_wr_t     store_wr,
    output logic                         pop,
    input  wire mbsp_pkg::cmd_t          pop_data,
    input  wire mbsp_pkg::fifo_status_t  fifo_status,
    output logic                         store_done,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output mbsp_pkg::out_item_t          m_item
);
    import mbsp_pkg::*;

    logic [7:0] store_mem [BUFFER_DEPTH];
    logic [7:0] rd_data_reg;

    back_state_t state_reg, state_next;
    cmd_t        cmd_reg;
    logic [LEN_W-1:0] idx_reg, idx_plus;

    logic      m_valid_reg;
    out_item_t m_item_reg;

    logic out_free, final_byte;
    logic load_single, load_store, start_store;

    assign out_free   = !m_valid_reg || m_ready;
    assign idx_plus   = idx_reg + LEN_W'(1);
    assign final_byte = (idx_plus == cmd_reg.len);
    assign m_valid    = m_valid_reg;
    assign m_item     = m_item_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (!fifo_status.empty && out_free && pop_data.from_store) begin
                    state_next = BK_READ;
                end
            end
            BK_READ: state_next = BK_SEND;
            BK_SEND: begin
                if (out_free) state_next = final_byte ? BK_IDLE : BK_READ;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        pop         = 1'b0;
        load_single = 1'b0;
        start_store = 1'b0;
        load_store  = 1'b0;
        store_done  = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                pop         = !fifo_status.empty && out_free;
                load_single = pop && !pop_data.from_store;
                start_store = pop && pop_data.from_store;
            end
            BK_READ: pop = 1'b0;
            BK_SEND: begin
                load_store = out_free;
                store_done = out_free && final_byte;
            end
            default: pop = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (store_wr.en) store_mem[store_wr.addr] <= store_wr.data;
        rd_data_reg <= store_mem[idx_reg[ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_single || load_store) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start_store) begin
            cmd_reg <= pop_data;
            idx_reg <= '0;
        end else if (load_store) begin
            idx_reg <= idx_plus;
        end
        if (load_single) begin
            m_item_reg.kind       <= pop_data.kind;
            m_item_reg.out_byte   <= pop_data.out_byte;
            m_item_reg.out_time   <= pop_data.out_time;
            m_item_reg.last       <= pop_data.last;
            m_item_reg.byte_count <= pop_data.byte_count;
            m_item_reg.lost_count <= pop_data.lost_count;
        end else if (load_store) begin
            m_item_reg.kind       <= KIND_MSG;
            m_item_reg.out_byte   <= rd_data_reg;
            m_item_reg.out_time   <= cmd_reg.out_time;
            m_item_reg.last       <= final_byte && cmd_reg.last;
            m_item_reg.byte_count <= '0;
            m_item_reg.lost_count <= '0;
        end
    end

endmodule

`default_nettype wire
